/* rtl/core/pwa_pkg.sv */
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared types and constants of the pose window averaging block.
// ----------------------------------------------------------------------------
package pwa_pkg;

	localparam int POS_W = 24;
	localparam int QUAT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam int SQ_W = 31;
	localparam int N2_W = 33;
	localparam int MAG_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;
	localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 4'd4;

	typedef struct packed {
		logic seen;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [QUAT_W-1:0] quat_w;
	} pose_t;

	typedef struct packed {
		logic out_seen;
		logic signed [POS_W-1:0] avg_x;
		logic signed [POS_W-1:0] avg_y;
		logic signed [POS_W-1:0] avg_z;
		logic signed [QUAT_W-1:0] avg_qx;
		logic signed [QUAT_W-1:0] avg_qy;
		logic signed [QUAT_W-1:0] avg_qz;
		logic signed [QUAT_W-1:0] avg_qw;
	} result_t;

	typedef struct packed {
		logic seen;
		logic [2:0][POS_W-1:0] pos;
		logic [3:0][QUAT_W-1:0] quat;
	} hist_entry_t;

endpackage

/* rtl/core/pwa_rdiv.sv */
// ----------------------------------------------------------------------------
// pwa_rdiv
// Restoring divider lane, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwa_rdiv #(
	parameter int NW = 27,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          ready,
	output logic [NW-1:0] quot
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic ready_q;
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ready_q <= 1'b0;
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ready_q <= 1'b0;
			cnt_q <= CNT_W'(NW);
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				ready_q <= 1'b1;
			end
		end
	end

	assign ready = ready_q;
	assign quot = num_q;

endmodule

/* rtl/core/pwa_norm.sv */
// ----------------------------------------------------------------------------
// pwa_norm
// Renormalization lane: serial divide of the scaled square by the squared norm,
// then a serial square root, giving one rounded unit-length magnitude.
// ----------------------------------------------------------------------------
module pwa_norm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pwa_pkg::SQ_W-1:0]   sq,
	input  logic [pwa_pkg::N2_W-1:0]   n2,
	output logic                       ready,
	output logic [pwa_pkg::MAG_W-1:0]  mag
);

	logic busy_q;
	logic sqrt_q;
	logic first_q;
	logic ready_q;
	logic [4:0] cnt_q;
	logic [33:0] r_q;
	logic [32:0] den_q;
	logic [31:0] q_q;
	logic [19:0] srem_q;
	logic [15:0] root_q;
	logic [33:0] dtrial;
	logic dge;
	logic [19:0] strial;
	logic [19:0] sval;
	logic sge;
	logic [16:0] root_inc;

	assign dtrial = first_q ? r_q : {r_q[32:0], 1'b0};
	assign dge = dtrial >= {1'b0, den_q};
	assign sval = {srem_q[17:0], q_q[31:30]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge = sval >= strial;
	assign root_inc = {1'b0, root_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sqrt_q <= 1'b0;
			first_q <= 1'b0;
			ready_q <= 1'b0;
			cnt_q <= '0;
			r_q <= '0;
			den_q <= '0;
			q_q <= '0;
			srem_q <= '0;
			root_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			sqrt_q <= 1'b0;
			first_q <= 1'b1;
			ready_q <= 1'b0;
			cnt_q <= 5'd30;
			r_q <= {3'b000, sq};
			den_q <= n2;
			q_q <= '0;
		end else if (busy_q && !sqrt_q) begin
			first_q <= 1'b0;
			r_q <= dge ? dtrial - {1'b0, den_q} : dtrial;
			q_q <= {q_q[30:0], dge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd0) begin
				sqrt_q <= 1'b1;
				cnt_q <= 5'd15;
				srem_q <= '0;
				root_q <= '0;
			end
		end else if (busy_q) begin
			srem_q <= sge ? sval - strial : sval;
			root_q <= {root_q[14:0], sge};
			q_q <= {q_q[29:0], 2'b00};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				ready_q <= 1'b1;
			end
		end
	end

	assign ready = ready_q;
	assign mag = root_inc[15:1];

endmodule

/* rtl/core/pwa_hist.sv */
// ----------------------------------------------------------------------------
// pwa_hist
// Pose history store and a sweep that sums the visible entries.
// ----------------------------------------------------------------------------
module pwa_hist #(
	parameter int WINDOW_MAX = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          wr_en,
	input  logic [$clog2(WINDOW_MAX)-1:0]                 wr_addr,
	input  pwa_pkg::hist_entry_t                          wr_entry,
	input  logic                                          start,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]               fill,
	output logic [2:0][pwa_pkg::POS_W+$clog2(WINDOW_MAX)-1:0]  psum,
	output logic [3:0][pwa_pkg::QUAT_W+$clog2(WINDOW_MAX)-1:0] qsum,
	output logic [$clog2(WINDOW_MAX+1)-1:0]               cnt,
	output logic                                          done
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int SW = pwa_pkg::POS_W + AW;
	localparam int QSW = pwa_pkg::QUAT_W + AW;

	pwa_pkg::hist_entry_t mem [WINDOW_MAX];
	pwa_pkg::hist_entry_t ent_s1;
	logic rd_busy_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] idx_inc;
	logic vld_s1;
	logic last_s1;
	logic done_q;
	logic [2:0][SW-1:0] psum_q;
	logic [3:0][QSW-1:0] qsum_q;
	logic [CW-1:0] cnt_q;

	assign idx_inc = rd_idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_busy_q) begin
			ent_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_busy_q <= 1'b0;
			rd_idx_q <= '0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
			psum_q <= '0;
			qsum_q <= '0;
			cnt_q <= '0;
		end else begin
			vld_s1 <= rd_busy_q;
			last_s1 <= rd_busy_q && (idx_inc == fill);
			done_q <= last_s1;
			if (start) begin
				rd_busy_q <= 1'b1;
				rd_idx_q <= '0;
				psum_q <= '0;
				qsum_q <= '0;
				cnt_q <= '0;
			end else begin
				if (rd_busy_q) begin
					rd_idx_q <= idx_inc;
					if (idx_inc == fill) begin
						rd_busy_q <= 1'b0;
					end
				end
				if (vld_s1 && ent_s1.seen) begin
					cnt_q <= cnt_q + 1'b1;
					for (int k = 0; k < 3; k++) begin
						psum_q[k] <= psum_q[k]
							+ {{AW{ent_s1.pos[k][pwa_pkg::POS_W-1]}}, ent_s1.pos[k]};
					end
					for (int k = 0; k < 4; k++) begin
						qsum_q[k] <= qsum_q[k]
							+ {{AW{ent_s1.quat[k][pwa_pkg::QUAT_W-1]}}, ent_s1.quat[k]};
					end
				end
			end
		end
	end

	assign psum = psum_q;
	assign qsum = qsum_q;
	assign cnt = cnt_q;
	assign done = done_q;

endmodule

/* rtl/core/pose_window_average.sv */
// ----------------------------------------------------------------------------
// pose_window_average
// Windowed moving average of tracked poses with quaternion renormalization.
//
//   Channel  Signals                          Transaction when
//   pose     pose_valid, pose_stall, pose     pose_valid && !pose_stall
//   result   result_valid, result_stall, ...  result_valid && !result_stall
//   cfg      cfg_valid, cfg_ready, index/data cfg_valid && cfg_ready
//
// A pass-through pose is captured and then written to the output register. An
// averaged pose passes through the history sweep, the bit-serial mean
// dividers and the serial divide and square root of the renormalization
// lanes. A window with no visible pose skips the mean dividers.
// One pose is in work at a time; the next is taken once the result is in the
// output register, which holds it while result_stall is high.
// Reset clears the control state and the history bookkeeping.
// ----------------------------------------------------------------------------
module pose_window_average #(
	parameter int WINDOW_MAX = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pose_valid,
	output logic                               pose_stall,
	input  pwa_pkg::pose_t                     pose,
	output logic                               result_valid,
	input  logic                               result_stall,
	output pwa_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pwa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int SW = pwa_pkg::POS_W + AW;
	localparam int QSW = pwa_pkg::QUAT_W + AW;

	typedef enum logic [2:0] {
		S_IDLE, S_ACC, S_MEAN, S_SQ, S_N2, S_NORM, S_DONE
	} state_t;

	state_t state_q;
	logic filter_en_q;
	logic [pwa_pkg::CFG_DATA_W-1:0] win_len_q;
	logic [AW-1:0] ws_q;
	logic [CW-1:0] fill_q;
	logic hist_start_q;
	logic div_start_q;
	logic norm_start_q;
	logic result_valid_q;
	pwa_pkg::result_t result_q;
	pwa_pkg::pose_t pose_q;
	logic [2:0][pwa_pkg::POS_W-1:0] res_pos_q;
	logic [3:0][pwa_pkg::QUAT_W-1:0] res_quat_q;
	logic signed [pwa_pkg::QUAT_W-1:0] mq_q [4];
	logic [pwa_pkg::SQ_W-1:0] sq_q [4];
	logic [1:0] sq_idx_q;
	logic [pwa_pkg::N2_W-1:0] n2_q;

	logic [CW-1:0] len_eff;
	logic [AW-1:0] slot;
	logic [AW-1:0] slot_next;
	logic [CW-1:0] fill_next;
	pwa_pkg::hist_entry_t wr_entry;
	logic [2:0][SW-1:0] hist_psum;
	logic [3:0][QSW-1:0] hist_qsum;
	logic [CW-1:0] hist_cnt;
	logic hist_done;
	logic [2:0][SW-1:0] pnum;
	logic [2:0][SW-1:0] pquot;
	logic [3:0][QSW-1:0] qnum;
	logic [3:0][QSW-1:0] qquot;
	logic [6:0] div_ready;
	logic [2:0][pwa_pkg::POS_W-1:0] pmean;
	logic [3:0][pwa_pkg::QUAT_W-1:0] qmean;
	logic signed [2*pwa_pkg::QUAT_W-1:0] prod;
	logic [pwa_pkg::N2_W-1:0] n2_sum;
	logic [3:0] norm_ready;
	logic [3:0][pwa_pkg::MAG_W-1:0] norm_mag;
	logic [3:0][pwa_pkg::QUAT_W-1:0] qnorm;

	always_comb begin
		if (win_len_q == '0) begin
			len_eff = CW'(1);
		end else if (32'(win_len_q) > WINDOW_MAX) begin
			len_eff = CW'(WINDOW_MAX);
		end else begin
			len_eff = CW'(win_len_q);
		end
		slot = (CW'(ws_q) >= len_eff) ? '0 : ws_q;
		slot_next = (CW'(slot) + CW'(1) == len_eff) ? '0 : slot + 1'b1;
		fill_next = (fill_q >= len_eff) ? len_eff : fill_q + 1'b1;
	end

	assign wr_entry.seen = pose.seen;
	assign wr_entry.pos = {pose.pos_z, pose.pos_y, pose.pos_x};
	assign wr_entry.quat = {pose.quat_w, pose.quat_z, pose.quat_y, pose.quat_x};

	pwa_hist #(.WINDOW_MAX(WINDOW_MAX)) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (pose_valid && !pose_stall && filter_en_q),
		.wr_addr  (slot),
		.wr_entry (wr_entry),
		.start    (hist_start_q),
		.fill     (fill_q),
		.psum     (hist_psum),
		.qsum     (hist_qsum),
		.cnt      (hist_cnt),
		.done     (hist_done)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pnum[k] = (hist_psum[k][SW-1] ? -hist_psum[k] : hist_psum[k])
				+ SW'(hist_cnt >> 1);
			pmean[k] = hist_psum[k][SW-1] ? pwa_pkg::POS_W'(-pquot[k])
				: pwa_pkg::POS_W'(pquot[k]);
		end
		for (int k = 0; k < 4; k++) begin
			qnum[k] = (hist_qsum[k][QSW-1] ? -hist_qsum[k] : hist_qsum[k])
				+ QSW'(hist_cnt >> 1);
			qmean[k] = hist_qsum[k][QSW-1] ? pwa_pkg::QUAT_W'(-qquot[k])
				: pwa_pkg::QUAT_W'(qquot[k]);
			qnorm[k] = mq_q[k][pwa_pkg::QUAT_W-1]
				? -{1'b0, norm_mag[k]} : {1'b0, norm_mag[k]};
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_pdiv
		pwa_rdiv #(.NW(SW), .DW(CW)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start_q),
			.num    (pnum[k]),
			.den    (hist_cnt),
			.ready  (div_ready[k]),
			.quot   (pquot[k])
		);
	end

	for (genvar k = 0; k < 4; k++) begin : g_qdiv
		pwa_rdiv #(.NW(QSW), .DW(CW)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start_q),
			.num    (qnum[k]),
			.den    (hist_cnt),
			.ready  (div_ready[3+k]),
			.quot   (qquot[k])
		);
	end

	for (genvar k = 0; k < 4; k++) begin : g_norm
		pwa_norm u_norm (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (norm_start_q),
			.sq     (sq_q[k]),
			.n2     (n2_q),
			.ready  (norm_ready[k]),
			.mag    (norm_mag[k])
		);
	end

	assign prod = mq_q[sq_idx_q] * mq_q[sq_idx_q];
	assign n2_sum = pwa_pkg::N2_W'(sq_q[0]) + pwa_pkg::N2_W'(sq_q[1])
		+ pwa_pkg::N2_W'(sq_q[2]) + pwa_pkg::N2_W'(sq_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			filter_en_q <= 1'b1;
			win_len_q <= pwa_pkg::WINDOW_RESET;
			ws_q <= '0;
			fill_q <= '0;
			hist_start_q <= 1'b0;
			div_start_q <= 1'b0;
			norm_start_q <= 1'b0;
			result_valid_q <= 1'b0;
			result_q <= '0;
			pose_q <= '0;
			res_pos_q <= '0;
			res_quat_q <= '0;
			mq_q <= '{default: '0};
			sq_q <= '{default: '0};
			sq_idx_q <= '0;
			n2_q <= '0;
		end else begin
			hist_start_q <= 1'b0;
			div_start_q <= 1'b0;
			norm_start_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					pwa_pkg::CFG_FILTER_ENABLE: filter_en_q <= cfg_data[0];
					pwa_pkg::CFG_WINDOW_LENGTH: begin
						win_len_q <= cfg_data;
						ws_q <= '0;
						fill_q <= '0;
					end
					default: ;
				endcase
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pose_valid) begin
						pose_q <= pose;
						res_pos_q <= {pose.pos_z, pose.pos_y, pose.pos_x};
						res_quat_q <= {pose.quat_w, pose.quat_z, pose.quat_y, pose.quat_x};
						mq_q[0] <= pose.quat_x;
						mq_q[1] <= pose.quat_y;
						mq_q[2] <= pose.quat_z;
						mq_q[3] <= pose.quat_w;
						state_q <= S_DONE;
						if (filter_en_q) begin
							ws_q <= slot_next;
							fill_q <= fill_next;
							if (fill_next >= CW'(2)) begin
								hist_start_q <= 1'b1;
								state_q <= S_ACC;
							end
						end
					end
				end
				S_ACC: begin
					if (hist_done) begin
						if (hist_cnt == '0) begin
							sq_idx_q <= '0;
							state_q <= S_SQ;
						end else begin
							div_start_q <= 1'b1;
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: begin
					if (!div_start_q && &div_ready) begin
						res_pos_q <= pmean;
						for (int k = 0; k < 4; k++) begin
							mq_q[k] <= qmean[k];
						end
						sq_idx_q <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sq_q[sq_idx_q] <= prod[pwa_pkg::SQ_W-1:0];
					sq_idx_q <= sq_idx_q + 1'b1;
					if (sq_idx_q == 2'd3) begin
						state_q <= S_N2;
					end
				end
				S_N2: begin
					if (n2_sum == '0) begin
						for (int k = 0; k < 4; k++) begin
							res_quat_q[k] <= mq_q[k];
						end
						state_q <= S_DONE;
					end else begin
						n2_q <= n2_sum;
						norm_start_q <= 1'b1;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!norm_start_q && &norm_ready) begin
						res_quat_q <= qnorm;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.out_seen <= pose_q.seen;
						result_q.avg_x <= res_pos_q[0];
						result_q.avg_y <= res_pos_q[1];
						result_q.avg_z <= res_pos_q[2];
						result_q.avg_qx <= res_quat_q[0];
						result_q.avg_qy <= res_quat_q[1];
						result_q.avg_qz <= res_quat_q[2];
						result_q.avg_qw <= res_quat_q[3];
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pose_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign cfg_ready = 1'b1;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("Result became valid outside the completion state.");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= WINDOW_MAX)
		else $error("History fill count exceeds the window capacity.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_stall |=> state_q != S_IDLE)
		else $error("Accepted pose transaction did not start processing.");

	a_sweep_in_acc: assert property (@(posedge clk) disable iff (!arst_n)
		hist_start_q |-> state_q == S_ACC && fill_q >= CW'(2))
		else $error("History sweep started without two held poses.");

endmodule
